// File: rtl/slvs_pkg.sv
// shared widths, constants and register codes for the spotlight vertex shader
package slvs_pkg;

    localparam int POS_W   = 24;              // Q12.12 positions
    localparam int NRM_W   = 16;              // Q1.14 normals and direction
    localparam int DIFF_W  = POS_W + 1;       // vertex minus light
    localparam int SQ_W    = 50;              // sum of squares, Q24.24
    localparam int DOT_W   = 43;              // dot products, Q12.26
    localparam int PROD_W  = DIFF_W + NRM_W;  // one dot product term
    localparam int RAD_W   = 62;              // sum of squares shifted up by 12
    localparam int RAD_SH  = RAD_W - SQ_W;
    localparam int ROOT_W  = RAD_W / 2;       // distance, Q12.18
    localparam int LPOS_W  = 41;              // positive lambert numerator
    localparam int LAM_SH  = 20;
    localparam int LAM_DW  = LPOS_W + LAM_SH; // lambert dividend
    localparam int LAM_W   = 55;              // lambert cosine, Q.28
    localparam int LAM_LO  = 28;              // split point for the intensity product
    localparam int ATT_W   = 51;              // attenuation, Q16.16
    localparam int NUM_SH  = 12;
    localparam int NUM_W   = 59;              // scaled numerator
    localparam int AMT_W   = 16;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 3;
    localparam int COEF_W  = 16;
    localparam int S8_LO   = 21;              // split point for the quadratic product
    localparam int ATT_EPS = 7;               // epsilon in Q16.16

    localparam logic [AMT_W-1:0] AMT_MAX = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_LIGHT_X   = 3'd0,
        REG_LIGHT_Y   = 3'd1,
        REG_LIGHT_Z   = 3'd2,
        REG_LIGHT_DIR = 3'd3,
        REG_CONE_COS  = 3'd4,
        REG_INTENSITY = 3'd5,
        REG_ATTEN     = 3'd6
    } cfg_reg_t;

    localparam logic [POS_W-1:0] LIGHT_RST     = '0;
    localparam logic [CFG_W-1:0] DIR_RST       = '0;
    localparam logic [NRM_W-1:0] CONE_RST      = '0;
    localparam logic [COEF_W-1:0] INTENS_RST   = 16'd256;
    localparam logic [CFG_W-1:0] ATTEN_RST     = 48'h0100_0100_0100;

endpackage

// File: rtl/spot_light_vertex_shade.sv
// top level of the spotlight vertex shader: registers, pipeline and output buffer
//
// Spotlight vertex shader. One vertex beat enters per clock while in_stall is
// low; the pipeline is fixed length with no dependence between vertices, so
// a steady stream gives one result per clock while out_stall is low. The depth
// is set by the 31-stage square root for the distance, the 55-stage divider
// for the Lambert cosine and the 16-stage divider by the attenuation. When
// out_stall holds results back, the pipeline keeps moving until its two-beat
// output buffer is full and only then raises in_stall. Registers are written
// through cfg_we/cfg_index/cfg_data and must only change while no vertex is
// in flight.
module spot_light_vertex_shade (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [slvs_pkg::IDX_W-1:0]        cfg_index,
    input  logic [slvs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [slvs_pkg::POS_W-1:0] vertex_x,
    input  logic signed [slvs_pkg::POS_W-1:0] vertex_y,
    input  logic signed [slvs_pkg::POS_W-1:0] vertex_z,
    input  logic signed [slvs_pkg::NRM_W-1:0] normal_x,
    input  logic signed [slvs_pkg::NRM_W-1:0] normal_y,
    input  logic signed [slvs_pkg::NRM_W-1:0] normal_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [slvs_pkg::AMT_W-1:0]        light_amount,
    output logic                              saturated
);

    localparam int SIDE1_W = 2 * slvs_pkg::DOT_W + slvs_pkg::SQ_W;
    localparam int SIDE2_W = slvs_pkg::ATT_W + 1;
    localparam int S8_W    = slvs_pkg::SQ_W - 8;
    localparam int QP_W    = slvs_pkg::COEF_W + slvs_pkg::S8_LO;
    localparam int QUAD_W  = slvs_pkg::COEF_W + S8_W;
    localparam int LIN_W   = slvs_pkg::COEF_W + slvs_pkg::ROOT_W;
    localparam int CONE_W  = slvs_pkg::NRM_W + slvs_pkg::ROOT_W + 1;
    localparam int PH_W    = slvs_pkg::LAM_W - slvs_pkg::LAM_LO + slvs_pkg::COEF_W;
    localparam int PL_W    = slvs_pkg::LAM_LO + slvs_pkg::COEF_W;
    localparam int MUL_W   = slvs_pkg::LAM_W + slvs_pkg::COEF_W;

    // configuration registers
    logic signed [slvs_pkg::POS_W-1:0]  light_x_reg;
    logic signed [slvs_pkg::POS_W-1:0]  light_y_reg;
    logic signed [slvs_pkg::POS_W-1:0]  light_z_reg;
    logic        [slvs_pkg::CFG_W-1:0]  light_dir_reg;
    logic signed [slvs_pkg::NRM_W-1:0]  cone_cos_reg;
    logic        [slvs_pkg::COEF_W-1:0] intensity_reg;
    logic        [slvs_pkg::CFG_W-1:0]  atten_reg;

    logic                               adv;

    // front and square root
    logic                               fr_v;
    logic        [slvs_pkg::SQ_W-1:0]   fr_s;
    logic signed [slvs_pkg::DOT_W-1:0]  fr_p;
    logic signed [slvs_pkg::DOT_W-1:0]  fr_l;
    logic                               sq_v;
    logic        [slvs_pkg::ROOT_W-1:0] sq_root;
    logic        [SIDE1_W-1:0]          sq_side;
    logic        [slvs_pkg::SQ_W-1:0]   sq_s;
    logic signed [slvs_pkg::DOT_W-1:0]  sq_p;
    logic signed [slvs_pkg::DOT_W-1:0]  sq_l;
    logic        [S8_W-1:0]             s8;

    // product stage
    logic                               e_v_reg;
    logic signed [CONE_W-1:0]           cone_e_reg;
    logic        [LIN_W-1:0]            lin_e_reg;
    logic        [QP_W-1:0]             qlo_e_reg;
    logic        [QP_W-1:0]             qhi_e_reg;
    logic signed [slvs_pkg::DOT_W-1:0]  p_e_reg;
    logic signed [slvs_pkg::DOT_W-1:0]  l_e_reg;
    logic                               zero_e_reg;
    logic        [slvs_pkg::ROOT_W-1:0] d18_e_reg;

    // attenuation and cone stage
    logic        [QUAD_W-1:0]           quad;
    logic signed [CONE_W:0]             p64;
    logic signed [CONE_W:0]             cone_ext;
    logic        [slvs_pkg::ATT_W-1:0]  att_next;
    logic                               kill_next;
    logic                               f_v_reg;
    logic        [slvs_pkg::ATT_W-1:0]  att_f_reg;
    logic                               kill_f_reg;
    logic        [slvs_pkg::LPOS_W-1:0] l_f_reg;
    logic        [slvs_pkg::ROOT_W-1:0] d18_f_reg;

    // lambert divider
    logic                               dv1_v;
    logic        [slvs_pkg::LAM_W-1:0]  lam;
    logic        [SIDE2_W-1:0]          dv1_side;

    // intensity product and scaling
    logic                               g_v_reg;
    logic        [PH_W-1:0]             ph_g_reg;
    logic        [PL_W-1:0]             pl_g_reg;
    logic        [slvs_pkg::ATT_W-1:0]  att_g_reg;
    logic                               kill_g_reg;
    logic        [MUL_W-1:0]            prod;
    logic                               h_v_reg;
    logic        [slvs_pkg::NUM_W-1:0]  n_h_reg;
    logic        [slvs_pkg::ATT_W-1:0]  att_h_reg;
    logic                               kill_h_reg;
    logic                               i_v_reg;
    logic        [slvs_pkg::NUM_W-1:0]  n_i_reg;
    logic        [slvs_pkg::ATT_W-1:0]  att_i_reg;
    logic                               kill_i_reg;
    logic                               sat_i_reg;

    // attenuation divider and output buffer
    logic                               dv2_v;
    logic        [slvs_pkg::AMT_W-1:0]  q16;
    logic        [1:0]                  dv2_side;
    logic        [slvs_pkg::AMT_W-1:0]  tail_amt;
    logic                               tail_sat;
    logic                               push;
    logic                               pop;
    logic        [1:0]                  cnt_reg;
    logic        [1:0]                  cnt_next;
    logic        [slvs_pkg::AMT_W-1:0]  amt0_reg;
    logic                               sat0_reg;
    logic        [slvs_pkg::AMT_W-1:0]  amt1_reg;
    logic                               sat1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg   <= slvs_pkg::LIGHT_RST;
            light_y_reg   <= slvs_pkg::LIGHT_RST;
            light_z_reg   <= slvs_pkg::LIGHT_RST;
            light_dir_reg <= slvs_pkg::DIR_RST;
            cone_cos_reg  <= slvs_pkg::CONE_RST;
            intensity_reg <= slvs_pkg::INTENS_RST;
            atten_reg     <= slvs_pkg::ATTEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slvs_pkg::REG_LIGHT_X:   light_x_reg   <= cfg_data[slvs_pkg::POS_W-1:0];
                slvs_pkg::REG_LIGHT_Y:   light_y_reg   <= cfg_data[slvs_pkg::POS_W-1:0];
                slvs_pkg::REG_LIGHT_Z:   light_z_reg   <= cfg_data[slvs_pkg::POS_W-1:0];
                slvs_pkg::REG_LIGHT_DIR: light_dir_reg <= cfg_data;
                slvs_pkg::REG_CONE_COS:  cone_cos_reg  <= cfg_data[slvs_pkg::NRM_W-1:0];
                slvs_pkg::REG_INTENSITY: intensity_reg <= cfg_data[slvs_pkg::COEF_W-1:0];
                slvs_pkg::REG_ATTEN:     atten_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipeline moves unless the output buffer is full
    assign adv      = (cnt_reg != 2'd2);
    assign in_stall = !adv;

    slvs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .vertex_z (vertex_z),
        .normal_x (normal_x),
        .normal_y (normal_y),
        .normal_z (normal_z),
        .light_x  (light_x_reg),
        .light_y  (light_y_reg),
        .light_z  (light_z_reg),
        .light_dir(light_dir_reg),
        .valid    (fr_v),
        .sum_sq   (fr_s),
        .dot_dir  (fr_p),
        .lambert  (fr_l)
    );

    slvs_sqrt #(
        .RAD_W  (slvs_pkg::RAD_W),
        .SIDE_W (SIDE1_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_v),
        .radicand  ({fr_s, {slvs_pkg::RAD_SH{1'b0}}}),
        .in_side   ({fr_p, fr_l, fr_s}),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign sq_s = sq_side[slvs_pkg::SQ_W-1:0];
    assign sq_l = sq_side[slvs_pkg::SQ_W +: slvs_pkg::DOT_W];
    assign sq_p = sq_side[slvs_pkg::SQ_W + slvs_pkg::DOT_W +: slvs_pkg::DOT_W];
    assign s8   = sq_s[slvs_pkg::SQ_W-1:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_v_reg <= sq_v;
            f_v_reg <= e_v_reg;
            g_v_reg <= dv1_v;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
        end
    end

    always_comb
    begin
        quad      = {qhi_e_reg, {slvs_pkg::S8_LO{1'b0}}} + QUAD_W'(qlo_e_reg);
        att_next  = slvs_pkg::ATT_W'({atten_reg[15:0], 8'b0})
                  + slvs_pkg::ATT_W'(lin_e_reg[LIN_W-1:10])
                  + slvs_pkg::ATT_W'(quad[QUAD_W-1:8])
                  + slvs_pkg::ATT_W'(slvs_pkg::ATT_EPS);
        p64       = {p_e_reg, 6'b0};
        cone_ext  = (CONE_W+1)'(cone_e_reg);
        // zero distance, outside the cone or facing away give a zero result
        kill_next = zero_e_reg || (p64 < cone_ext) || (l_e_reg <= 0);
        prod      = {ph_g_reg, {slvs_pkg::LAM_LO{1'b0}}} + MUL_W'(pl_g_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cone_e_reg <= cone_cos_reg * $signed({1'b0, sq_root});
            lin_e_reg  <= atten_reg[31:16] * sq_root;
            qlo_e_reg  <= atten_reg[47:32] * s8[slvs_pkg::S8_LO-1:0];
            qhi_e_reg  <= atten_reg[47:32] * s8[S8_W-1:slvs_pkg::S8_LO];
            p_e_reg    <= sq_p;
            l_e_reg    <= sq_l;
            zero_e_reg <= (sq_s == '0);
            d18_e_reg  <= sq_root;

            att_f_reg  <= att_next;
            kill_f_reg <= kill_next;
            l_f_reg    <= l_e_reg[slvs_pkg::LPOS_W-1:0];
            d18_f_reg  <= d18_e_reg;

            ph_g_reg   <= lam[slvs_pkg::LAM_W-1:slvs_pkg::LAM_LO] * intensity_reg;
            pl_g_reg   <= lam[slvs_pkg::LAM_LO-1:0] * intensity_reg;
            att_g_reg  <= dv1_side[slvs_pkg::ATT_W-1:0];
            kill_g_reg <= dv1_side[slvs_pkg::ATT_W];

            n_h_reg    <= prod[MUL_W-1:slvs_pkg::NUM_SH];
            att_h_reg  <= att_g_reg;
            kill_h_reg <= kill_g_reg;

            n_i_reg    <= n_h_reg;
            att_i_reg  <= att_h_reg;
            kill_i_reg <= kill_h_reg;
            // quotient above the Q8.8 range
            sat_i_reg  <= n_h_reg[slvs_pkg::NUM_W-1:slvs_pkg::AMT_W] >= att_h_reg;
        end
    end

    slvs_div #(
        .DIVD_W (slvs_pkg::LAM_DW),
        .DIVS_W (slvs_pkg::ROOT_W),
        .Q_W    (slvs_pkg::LAM_W),
        .SIDE_W (SIDE2_W)
    ) u_div_lam (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_v_reg),
        .dividend  ({l_f_reg, {slvs_pkg::LAM_SH{1'b0}}}),
        .divisor   (d18_f_reg),
        .in_side   ({kill_f_reg, att_f_reg}),
        .out_valid (dv1_v),
        .quotient  (lam),
        .out_side  (dv1_side)
    );

    slvs_div #(
        .DIVD_W (slvs_pkg::NUM_W),
        .DIVS_W (slvs_pkg::ATT_W),
        .Q_W    (slvs_pkg::AMT_W),
        .SIDE_W (2)
    ) u_div_att (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (i_v_reg),
        .dividend  (n_i_reg),
        .divisor   (att_i_reg),
        .in_side   ({kill_i_reg, sat_i_reg}),
        .out_valid (dv2_v),
        .quotient  (q16),
        .out_side  (dv2_side)
    );

    always_comb
    begin
        tail_sat = !dv2_side[1] && dv2_side[0];
        if (dv2_side[1])
        begin
            tail_amt = '0;
        end
        else if (dv2_side[0])
        begin
            tail_amt = slvs_pkg::AMT_MAX;
        end
        else
        begin
            tail_amt = q16;
        end
        push     = adv && dv2_v;
        pop      = out_valid && !out_stall;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // two-beat output buffer, head drives the result port
    always_ff @(posedge clk)
    begin
        if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        begin
            amt0_reg <= tail_amt;
            sat0_reg <= tail_sat;
        end
        else if (pop && cnt_reg == 2'd2)
        begin
            amt0_reg <= amt1_reg;
            sat0_reg <= sat1_reg;
        end
        if (push && !pop && cnt_reg == 2'd1)
        begin
            amt1_reg <= tail_amt;
            sat1_reg <= tail_sat;
        end
    end

    assign out_valid    = (cnt_reg != 2'd0);
    assign light_amount = amt0_reg;
    assign saturated    = sat0_reg;

endmodule

// File: rtl/slvs_front.sv
// front stages: light-to-vertex vector, products and dot-product sums
module slvs_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [slvs_pkg::POS_W-1:0]   vertex_x,
    input  logic signed [slvs_pkg::POS_W-1:0]   vertex_y,
    input  logic signed [slvs_pkg::POS_W-1:0]   vertex_z,
    input  logic signed [slvs_pkg::NRM_W-1:0]   normal_x,
    input  logic signed [slvs_pkg::NRM_W-1:0]   normal_y,
    input  logic signed [slvs_pkg::NRM_W-1:0]   normal_z,
    input  logic signed [slvs_pkg::POS_W-1:0]   light_x,
    input  logic signed [slvs_pkg::POS_W-1:0]   light_y,
    input  logic signed [slvs_pkg::POS_W-1:0]   light_z,
    input  logic        [slvs_pkg::CFG_W-1:0]   light_dir,
    output logic                                valid,
    output logic        [slvs_pkg::SQ_W-1:0]    sum_sq,
    output logic signed [slvs_pkg::DOT_W-1:0]   dot_dir,
    output logic signed [slvs_pkg::DOT_W-1:0]   lambert
);

    logic                               va_reg;
    logic                               vb_reg;
    logic                               vc_reg;
    logic signed [slvs_pkg::DIFF_W-1:0] d_next   [3];
    logic signed [slvs_pkg::DIFF_W-1:0] d_reg    [3];
    logic signed [slvs_pkg::NRM_W-1:0]  n_reg    [3];
    logic signed [slvs_pkg::NRM_W-1:0]  u        [3];
    logic signed [slvs_pkg::SQ_W-1:0]   sq_next  [3];
    logic signed [slvs_pkg::SQ_W-1:0]   sq_reg   [3];
    logic signed [slvs_pkg::PROD_W-1:0] pu_next  [3];
    logic signed [slvs_pkg::PROD_W-1:0] pu_reg   [3];
    logic signed [slvs_pkg::PROD_W-1:0] pn_next  [3];
    logic signed [slvs_pkg::PROD_W-1:0] pn_reg   [3];
    logic signed [slvs_pkg::SQ_W:0]     ssum;
    logic signed [slvs_pkg::DOT_W-1:0]  psum;
    logic signed [slvs_pkg::DOT_W-1:0]  nsum;
    logic        [slvs_pkg::SQ_W-1:0]   s_reg;
    logic signed [slvs_pkg::DOT_W-1:0]  p_reg;
    logic signed [slvs_pkg::DOT_W-1:0]  l_reg;

    assign u[0] = light_dir[15:0];
    assign u[1] = light_dir[31:16];
    assign u[2] = light_dir[47:32];

    always_comb
    begin
        d_next[0] = {vertex_x[slvs_pkg::POS_W-1], vertex_x} - {light_x[slvs_pkg::POS_W-1], light_x};
        d_next[1] = {vertex_y[slvs_pkg::POS_W-1], vertex_y} - {light_y[slvs_pkg::POS_W-1], light_y};
        d_next[2] = {vertex_z[slvs_pkg::POS_W-1], vertex_z} - {light_z[slvs_pkg::POS_W-1], light_z};
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = d_reg[i] * d_reg[i];
            pu_next[i] = d_reg[i] * u[i];
            pn_next[i] = d_reg[i] * n_reg[i];
        end
        ssum = (slvs_pkg::SQ_W+1)'(sq_reg[0]) + (slvs_pkg::SQ_W+1)'(sq_reg[1])
             + (slvs_pkg::SQ_W+1)'(sq_reg[2]);
        psum = slvs_pkg::DOT_W'(pu_reg[0]) + slvs_pkg::DOT_W'(pu_reg[1])
             + slvs_pkg::DOT_W'(pu_reg[2]);
        nsum = slvs_pkg::DOT_W'(pn_reg[0]) + slvs_pkg::DOT_W'(pn_reg[1])
             + slvs_pkg::DOT_W'(pn_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= d_next;
            n_reg[0] <= normal_x;
            n_reg[1] <= normal_y;
            n_reg[2] <= normal_z;
            sq_reg   <= sq_next;
            pu_reg   <= pu_next;
            pn_reg   <= pn_next;
            s_reg    <= ssum[slvs_pkg::SQ_W-1:0];
            p_reg    <= psum;
            // lambert numerator points from the vertex toward the light
            l_reg    <= -nsum;
        end
    end

    assign valid   = vc_reg;
    assign sum_sq  = s_reg;
    assign dot_dir = p_reg;
    assign lambert = l_reg;

endmodule

// File: rtl/slvs_sqrt.sv
// pipelined integer square root, one root bit per stage
module slvs_sqrt #(
    parameter int RAD_W  = slvs_pkg::RAD_W,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      radicand,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int STEPS  = ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    wire              v_st    [STEPS+1];
    wire [RAD_W-1:0]  x_st    [STEPS+1];
    wire [REM_W-1:0]  rem_st  [STEPS+1];
    wire [ROOT_W-1:0] root_st [STEPS+1];
    wire [SIDE_W-1:0] side_st [STEPS+1];

    assign v_st[0]    = in_valid;
    assign x_st[0]    = radicand;
    assign rem_st[0]  = '0;
    assign root_st[0] = '0;
    assign side_st[0] = in_side;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic              v_reg;
        logic [RAD_W-1:0]  x_reg;
        logic [REM_W-1:0]  rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;

        always_comb
        begin
            // bring down the next two radicand bits and try root*4+1
            cur   = {rem_st[k], x_st[k][RAD_W-1 -: 2]};
            trial = {2'b00, root_st[k], 2'b01};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v_st[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg    <= x_st[k] << 2;
                side_reg <= side_st[k];
                if (cur >= trial)
                begin
                    rem_reg  <= REM_W'(cur - trial);
                    root_reg <= {root_st[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= cur[REM_W-1:0];
                    root_reg <= {root_st[k][ROOT_W-2:0], 1'b0};
                end
            end
        end

        assign v_st[k+1]    = v_reg;
        assign x_st[k+1]    = x_reg;
        assign rem_st[k+1]  = rem_reg;
        assign root_st[k+1] = root_reg;
        assign side_st[k+1] = side_reg;
    end

    assign out_valid = v_st[STEPS];
    assign root      = root_st[STEPS];
    assign out_side  = side_st[STEPS];

endmodule

// File: rtl/slvs_div.sv
// pipelined restoring divider, one quotient bit per stage
module slvs_div #(
    parameter int DIVD_W = 8,
    parameter int DIVS_W = 8,
    parameter int Q_W    = 4,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quotient,
    output logic [SIDE_W-1:0] out_side
);

    localparam int TOP_W = DIVD_W - Q_W;

    wire              v_st    [Q_W+1];
    wire [DIVS_W-1:0] r_st    [Q_W+1];
    wire [Q_W-1:0]    low_st  [Q_W+1];
    wire [DIVS_W-1:0] d_st    [Q_W+1];
    wire [SIDE_W-1:0] side_st [Q_W+1];

    // the top dividend bits must already sit below the divisor
    assign v_st[0]    = in_valid;
    assign r_st[0]    = {{(DIVS_W-TOP_W){1'b0}}, dividend[DIVD_W-1 -: TOP_W]};
    assign low_st[0]  = dividend[Q_W-1:0];
    assign d_st[0]    = divisor;
    assign side_st[0] = in_side;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic              v_reg;
        logic [DIVS_W-1:0] r_reg;
        logic [Q_W-1:0]    low_reg;
        logic [DIVS_W-1:0] d_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [DIVS_W:0]   cur;
        logic              ge;

        always_comb
        begin
            cur = {r_st[k], low_st[k][Q_W-1]};
            ge  = cur >= {1'b0, d_st[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v_st[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // dividend bits leave at the top, quotient bits enter at the bottom
                low_reg  <= {low_st[k][Q_W-2:0], ge};
                d_reg    <= d_st[k];
                side_reg <= side_st[k];
                if (ge)
                begin
                    r_reg <= DIVS_W'(cur - {1'b0, d_st[k]});
                end
                else
                begin
                    r_reg <= cur[DIVS_W-1:0];
                end
            end
        end

        assign v_st[k+1]    = v_reg;
        assign r_st[k+1]    = r_reg;
        assign low_st[k+1]  = low_reg;
        assign d_st[k+1]    = d_reg;
        assign side_st[k+1] = side_reg;
    end

    assign out_valid = v_st[Q_W];
    assign quotient  = low_st[Q_W];
    assign out_side  = side_st[Q_W];

endmodule

// File: rtl/slvs_check.sv
// port checker for the spotlight vertex shader, bound to the top level
module slvs_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [slvs_pkg::AMT_W-1:0] light_amount,
    input logic                       saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(light_amount) && $stable(saturated))
        else $error("stalled result beat changed");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> light_amount == slvs_pkg::AMT_MAX)
        else $error("saturated beat not at full scale");

    a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output buffer");

    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("input still stalled after a result beat left");

endmodule

bind spot_light_vertex_shade slvs_check u_slvs_check (.*);

// File: test/testbench.sv
// testbench for the spotlight vertex shader: random vertices, config phases, scoreboard check
`timescale 1ns / 1ps

class shade_scoreboard;
    logic signed [slvs_pkg::POS_W-1:0] lx, ly, lz;
    logic [slvs_pkg::CFG_W-1:0]        dir;
    logic signed [slvs_pkg::NRM_W-1:0] cone;
    logic [slvs_pkg::COEF_W-1:0]       inten;
    logic [slvs_pkg::CFG_W-1:0]        coef;
    logic [slvs_pkg::AMT_W-1:0]        amount_q[$];
    logic                              sat_q[$];
    int                                errors;

    function new();
        lx = slvs_pkg::LIGHT_RST;
        ly = slvs_pkg::LIGHT_RST;
        lz = slvs_pkg::LIGHT_RST;
        dir = slvs_pkg::DIR_RST;
        cone = slvs_pkg::CONE_RST;
        inten = slvs_pkg::INTENS_RST;
        coef = slvs_pkg::ATTEN_RST;
        errors = 0;
    endfunction

    function void set_reg(logic [slvs_pkg::IDX_W-1:0] idx, logic [slvs_pkg::CFG_W-1:0] v);
        case (idx)
            slvs_pkg::REG_LIGHT_X:   lx = v[23:0];
            slvs_pkg::REG_LIGHT_Y:   ly = v[23:0];
            slvs_pkg::REG_LIGHT_Z:   lz = v[23:0];
            slvs_pkg::REG_LIGHT_DIR: dir = v;
            slvs_pkg::REG_CONE_COS:  cone = v[15:0];
            slvs_pkg::REG_INTENSITY: inten = v[15:0];
            slvs_pkg::REG_ATTEN:     coef = v;
            default: ;
        endcase
    endfunction

    function longint unsigned int_root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function int pending();
        return amount_q.size();
    endfunction

    // work out the light for one accepted vertex beat
    function void note_vertex(logic signed [23:0] vx, logic signed [23:0] vy,
                              logic signed [23:0] vz, logic signed [15:0] nx,
                              logic signed [15:0] ny, logic signed [15:0] nz);
        longint dx, dy, dz, p, l;
        longint unsigned s, d18, lam, att, q;
        logic [15:0] amt;
        logic sat;
        amt = '0;
        sat = 1'b0;
        dx = longint'(vx) - longint'(lx);
        dy = longint'(vy) - longint'(ly);
        dz = longint'(vz) - longint'(lz);
        s = dx * dx + dy * dy + dz * dz;
        if (s != 0)
        begin
            d18 = int_root(s << 12);
            p = dx * longint'($signed(dir[15:0])) + dy * longint'($signed(dir[31:16]))
                + dz * longint'($signed(dir[47:32]));
            l = -(dx * longint'(nx) + dy * longint'(ny) + dz * longint'(nz));
            if (p * 64 >= longint'(cone) * longint'(d18) && l > 0)
            begin
                lam = (longint'(l) << 20) / d18;
                att = (longint'(coef[15:0]) << 8) + ((longint'(coef[31:16]) * d18) >> 10)
                      + ((longint'(coef[47:32]) * (s >> 8)) >> 8) + slvs_pkg::ATT_EPS;
                q = (lam * longint'(inten)) / (att << 12);
                if (q > 65535)
                begin
                    amt = slvs_pkg::AMT_MAX;
                    sat = 1'b1;
                end
                else
                    amt = q[15:0];
            end
        end
        amount_q.push_back(amt);
        sat_q.push_back(sat);
    endfunction

    function void check_light(logic [15:0] amt, logic sat);
        logic [15:0] e_amt;
        logic e_sat;
        if (amount_q.size() == 0)
        begin
            $display("%0t: unexpected result amount %0d sat %0d", $time, amt, sat);
            errors++;
            return;
        end
        e_amt = amount_q.pop_front();
        e_sat = sat_q.pop_front();
        if (amt !== e_amt)
        begin
            $display("%0t: light_amount expected %0d actual %0d", $time, e_amt, amt);
            errors++;
        end
        if (sat !== e_sat)
        begin
            $display("%0t: saturated expected %0d actual %0d", $time, e_sat, sat);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam logic [slvs_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LATENCY = 111;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk, rst_n;
    logic cfg_we;
    logic [slvs_pkg::IDX_W-1:0] cfg_index;
    logic [slvs_pkg::CFG_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall, saturated;
    logic signed [slvs_pkg::POS_W-1:0] vertex_x, vertex_y, vertex_z;
    logic signed [slvs_pkg::NRM_W-1:0] normal_x, normal_y, normal_z;
    logic [slvs_pkg::AMT_W-1:0] light_amount;

    int send_idle_pct, recv_stall_pct, hold_cycles;
    longint cycles;
    shade_scoreboard sb;

    spot_light_vertex_shade DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // input monitor
    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            sb.note_vertex(vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z);

    // result side: check and choose next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_light(light_amount, saturated);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(logic [slvs_pkg::IDX_W-1:0] idx, logic [slvs_pkg::CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                               logic [15:0] a, logic [15:0] b, logic [15:0] c);
        in_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        normal_x <= a;
        normal_y <= b;
        normal_z <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // each idle cycle is drawn on its own
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config(bit extreme);
        logic [15:0] ux, uy, uz;
        write_reg(slvs_pkg::REG_LIGHT_X,
                  extreme ? 48'h800000 : 48'($urandom_range(8191) - 4096));
        write_reg(slvs_pkg::REG_LIGHT_Y,
                  extreme ? 48'h7FFFFF : 48'($urandom_range(8191) - 4096));
        write_reg(slvs_pkg::REG_LIGHT_Z, 48'($urandom_range(8191) - 4096));
        case ($urandom_range(3))
            0: begin ux = 16'd16384; uy = 16'd0; uz = 16'd0; end
            1: begin ux = 16'd0; uy = -16'sd16384; uz = 16'd0; end
            2: begin ux = 16'd9459; uy = 16'd9459; uz = -16'sd9459; end
            default: begin ux = 16'($urandom); uy = 16'($urandom); uz = 16'($urandom); end
        endcase
        write_reg(slvs_pkg::REG_LIGHT_DIR, {uz, uy, ux});
        write_reg(slvs_pkg::REG_CONE_COS,
                  extreme ? 48'(16'h8000) : 48'(16'($urandom_range(16384))));
        write_reg(slvs_pkg::REG_INTENSITY, extreme ? 48'hFFFF : 48'($urandom_range(65535)));
        write_reg(slvs_pkg::REG_ATTEN, extreme ? {16'($urandom_range(1)), 16'd0, 16'd0}
                                               : {16'($urandom_range(600)),
                                                  16'($urandom_range(600)),
                                                  16'($urandom_range(600))});
        write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
    endtask

    // mostly vertices along the light axis facing the light, some raw noise
    task automatic random_vertices(int n);
        int k;
        logic signed [23:0] ox, oy, oz;
        logic signed [15:0] ux, uy, uz;
        logic [15:0] nx, ny, nz;
        repeat (n)
        begin
            if ($urandom_range(99) < 75)
            begin
                ux = sb.dir[15:0];
                uy = sb.dir[31:16];
                uz = sb.dir[47:32];
                k = $urandom_range(8);
                ox = 24'(((int'(ux) >>> 4) <<< k) + int'($urandom_range(255)) - 128);
                oy = 24'(((int'(uy) >>> 4) <<< k) + int'($urandom_range(255)) - 128);
                oz = 24'(((int'(uz) >>> 4) <<< k) + int'($urandom_range(255)) - 128);
                nx = 16'(-int'(ux) + int'($urandom_range(511)) - 256);
                ny = 16'(-int'(uy) + int'($urandom_range(511)) - 256);
                nz = 16'(-int'(uz) + int'($urandom_range(511)) - 256);
                send_vertex(sb.lx + ox, sb.ly + oy, sb.lz + oz, nx, ny, nz);
            end
            else
                send_vertex(24'($urandom), 24'($urandom), 24'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        vertex_x = '0;
        vertex_y = '0;
        vertex_z = '0;
        normal_x = '0;
        normal_y = '0;
        normal_z = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, zero distance, facing away, extremes
        send_vertex(24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd16384);
        send_vertex(24'd4096, 24'd0, 24'd0, -16'sd16384, 16'd0, 16'd0);
        send_vertex(24'd4096, 24'd0, 24'd0, 16'd16384, 16'd0, 16'd0);
        send_vertex(24'd0, 24'd0, 24'd16, 16'd0, 16'd0, -16'sd16384);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h8000, 16'h8000);
        send_vertex(24'h800000, 24'h800000, 24'h800000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(24'd1, 24'd0, 24'd0, -16'sd16384, 16'd0, 16'd0);
        send_vertex(24'd0, -24'sd1, 24'd0, 16'd0, 16'd16384, 16'd0);
        idle_sender();
        drain();
        write_reg(slvs_pkg::REG_LIGHT_DIR, {16'd0, 16'd0, 16'd16384});
        write_reg(slvs_pkg::REG_CONE_COS, 48'd14189);
        write_reg(slvs_pkg::REG_INTENSITY, 48'hFFFF);
        write_reg(slvs_pkg::REG_ATTEN, 48'd0);
        send_vertex(24'd4096, 24'd0, 24'd0, -16'sd16384, 16'd0, 16'd0);
        send_vertex(24'd16, 24'd0, 24'd0, -16'sd16384, 16'd0, 16'd0);
        send_vertex(24'd0, 24'd4096, 24'd0, 16'd0, -16'sd16384, 16'd0);
        send_vertex(24'd4096, 24'd4096, 24'd0, -16'sd11585, -16'sd11585, 16'd0);
        send_vertex(-24'sd4096, 24'd0, 24'd0, 16'd16384, 16'd0, 16'd0);
        send_vertex(24'd409600, 24'd0, 24'd0, -16'sd16384, 16'd0, 16'd0);
        idle_sender();
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            random_config(ph == 1 || ph == 5);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 68; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 68; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 4)
            begin
                send_idle_pct = 0;
                hold_cycles = 400;
            end
            random_vertices(ph == 0 ? 200 : 185);
            idle_sender();
            drain();
        end

        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: sim.f
rtl/slvs_pkg.sv
rtl/slvs_front.sv
rtl/slvs_sqrt.sv
rtl/slvs_div.sv
rtl/spot_light_vertex_shade.sv
rtl/slvs_check.sv
test/testbench.sv
